/* rtl/mpc_pkg.sv */
// Shared types, codes and helpers for the pc sequencer and COP0 exception unit.
// No dependencies; imported by the input channel interface and the core.
`default_nettype none

package mpc_pkg;

  // Event codes carried on the input channel
  typedef enum logic [3:0] {
    ACT_FETCH     = 4'd0,
    ACT_JUMP      = 4'd1,
    ACT_BRANCH    = 4'd2,
    ACT_EXCEPTION = 4'd3,
    ACT_EXIT_EXC  = 4'd4,
    ACT_COP0_RD   = 4'd5,
    ACT_COP0_WR   = 4'd6,
    ACT_SOFT_RST  = 4'd7,
    ACT_DATA      = 4'd8
  } action_e;

  // COP0 register numbers
  localparam logic [4:0] REG_BPC      = 5'd3;
  localparam logic [4:0] REG_BDA      = 5'd5;
  localparam logic [4:0] REG_JUMPDEST = 5'd6;
  localparam logic [4:0] REG_DCIC     = 5'd7;
  localparam logic [4:0] REG_BDAM     = 5'd9;
  localparam logic [4:0] REG_BPCM     = 5'd11;
  localparam logic [4:0] REG_SR       = 5'd12;
  localparam logic [4:0] REG_CAUSE    = 5'd13;
  localparam logic [4:0] REG_EPC      = 5'd14;

  // Exception codes
  localparam logic [4:0] EXC_ADDR_LOAD = 5'd4;

  // Vectors and status / cause masks
  localparam logic [31:0] RESET_VECTOR  = 32'hbfc0_0000;
  localparam logic [31:0] VECTOR_RAM    = 32'h8000_0080;
  localparam logic [31:0] VECTOR_BOOT   = 32'hbfc0_0180;
  localparam logic [31:0] SR_IEC        = 32'h0000_0001;
  localparam logic [31:0] SR_KUC        = 32'h0000_0002;
  localparam logic [31:0] SR_TS         = 32'h0020_0000;
  localparam logic [31:0] SR_BEV        = 32'h0040_0000;
  localparam logic [31:0] SR_RESET      = SR_BEV | SR_TS;
  localparam logic [31:0] CAUSE_IP_SW   = 32'h0000_0300;
  localparam int unsigned SR_ISC_BIT    = 16;
  localparam int unsigned SR_BEV_BIT    = 22;
  localparam int unsigned CAUSE_BD_BIT  = 31;

  // One result word
  typedef struct packed {
    logic [31:0] phys_address;
    logic [31:0] read_value;
    logic        fetch_fault;
    logic        access_suppressed;
    logic        bad_register;
    logic [31:0] pc_value;
    logic [31:0] next_pc_value;
  } result_t;

  // Segment map: kseg0 drops bit 31, kseg1 drops bits 31:29
  function automatic logic [31:0] map_address(input logic [31:0] a);
    logic [31:0] m;
    m = a;
    if (a[31:29] == 3'd4) begin
      m = a & 32'h7fff_ffff;
    end else if (a[31:29] == 3'd5) begin
      m = a & 32'h1fff_ffff;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/mpc_if.sv */
// Valid/ready channel interfaces for the event input and the result output.
// Depends on mpc_pkg for the event code type.
`default_nettype none

interface mpc_in_if
  import mpc_pkg::*;
();
  logic        valid;
  logic        ready;
  action_e     action;
  logic [31:0] target_address;
  logic signed [31:0] branch_offset;
  logic [4:0]  exc_code;
  logic [4:0]  reg_index;
  logic [31:0] write_value;
  logic [31:0] data_address;

  modport source (output valid, action, target_address, branch_offset, exc_code,
                  reg_index, write_value, data_address, input ready);
  modport sink (input valid, action, target_address, branch_offset, exc_code,
                reg_index, write_value, data_address, output ready);
endinterface

interface mpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_address;
  logic [31:0] read_value;
  logic        fetch_fault;
  logic        access_suppressed;
  logic        bad_register;
  logic [31:0] pc_value;
  logic [31:0] next_pc_value;

  modport source (output valid, phys_address, read_value, fetch_fault,
                  access_suppressed, bad_register, pc_value, next_pc_value,
                  input ready);
  modport sink (input valid, phys_address, read_value, fetch_fault,
                access_suppressed, bad_register, pc_value, next_pc_value,
                output ready);
endinterface

`default_nettype wire

/* rtl/mips_pc_and_cop0_exception_unit_core.sv */
// PC sequencer and COP0 exception unit: one event word in, one result word out.
// Each result word is registered in the output register, or in the skid stage while the output is held.
// Throughput: one event word per cycle while the skid stage is empty; all state updates in the cycle of accept.
// An output register plus one skid stage lets input take one more word while a result waits.
// Reset (rst_ni low, asynchronous): pc and current pc 0xbfc00000, next pc
// 0xbfc00004, SR 0x00600000, CAUSE and EPC 0, branch flags clear, output empty.
`default_nettype none

module mips_pc_and_cop0_exception_unit_core
  import mpc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpc_in_if.sink    in_i,
  mpc_out_if.source out_o
);

  // Architectural state
  logic [31:0] pc_q, pc_d;
  logic [31:0] exec_pc_q, exec_pc_d;
  logic [31:0] next_pc_q, next_pc_d;
  logic        branch_q, branch_d;
  logic        delay_q, delay_d;
  logic [31:0] sr_q, sr_d;
  logic [31:0] cause_q, cause_d;
  logic [31:0] epc_q, epc_d;

  // Output register and skid stage
  result_t     out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;

  logic        in_acc, out_free;
  logic        exc_take;
  logic [4:0]  exc_sel;
  logic [31:0] vector;

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Evaluate one event against the current state
  always_comb begin
    pc_d      = pc_q;
    exec_pc_d = exec_pc_q;
    next_pc_d = next_pc_q;
    branch_d  = branch_q;
    delay_d   = delay_q;
    sr_d      = sr_q;
    cause_d   = cause_q;
    epc_d     = epc_q;
    exc_take  = 1'b0;
    exc_sel   = in_i.exc_code;
    vector    = sr_q[SR_BEV_BIT] ? VECTOR_BOOT : VECTOR_RAM;
    res       = '0;

    case (in_i.action)
      ACT_FETCH: begin
        if (pc_q[1:0] != 2'b00) begin
          exc_take        = 1'b1;
          exc_sel         = EXC_ADDR_LOAD;
          res.fetch_fault = 1'b1;
        end else begin
          res.phys_address = map_address(pc_q);
          exec_pc_d        = pc_q;
          pc_d             = next_pc_q;
          next_pc_d        = next_pc_q + 32'd4;
          delay_d          = branch_q;
          branch_d         = 1'b0;
        end
      end
      ACT_JUMP: begin
        branch_d  = 1'b1;
        next_pc_d = in_i.target_address;
      end
      ACT_BRANCH: begin
        branch_d  = 1'b1;
        next_pc_d = pc_q + in_i.branch_offset;
      end
      ACT_EXCEPTION: begin
        exc_take = 1'b1;
      end
      ACT_EXIT_EXC: begin
        // pop the mode stack
        sr_d[5:0] = {2'b00, sr_q[5:2]};
      end
      ACT_COP0_RD: begin
        case (in_i.reg_index)
          REG_SR:    res.read_value = sr_q;
          REG_CAUSE: res.read_value = cause_q;
          REG_EPC:   res.read_value = epc_q;
          default:   res.bad_register = 1'b1;
        endcase
      end
      ACT_COP0_WR: begin
        case (in_i.reg_index)
          REG_SR:    sr_d = in_i.write_value;
          REG_CAUSE: cause_d = (cause_q & ~CAUSE_IP_SW) | (in_i.write_value & CAUSE_IP_SW);
          REG_BPC, REG_BDA, REG_JUMPDEST, REG_DCIC, REG_BDAM, REG_BPCM: begin
          end
          default:   res.bad_register = 1'b1;
        endcase
      end
      ACT_SOFT_RST: begin
        sr_d      = (sr_q | SR_BEV | SR_TS) & ~(SR_KUC | SR_IEC);
        epc_d     = exec_pc_q;
        pc_d      = RESET_VECTOR;
        exec_pc_d = RESET_VECTOR;
        next_pc_d = RESET_VECTOR + 32'd4;
        branch_d  = 1'b0;
        delay_d   = 1'b0;
      end
      ACT_DATA: begin
        if (sr_q[SR_ISC_BIT]) begin
          res.access_suppressed = 1'b1;
        end else begin
          res.phys_address = map_address(in_i.data_address);
        end
      end
      default: begin
      end
    endcase

    // Exception entry: push mode stack, record BD, code and EPC, vector
    if (exc_take) begin
      sr_d[5:0]             = {sr_q[3:0], 2'b00};
      cause_d[CAUSE_BD_BIT] = delay_q;
      cause_d[6:2]          = exc_sel;
      epc_d                 = delay_q ? exec_pc_q - 32'd4 : exec_pc_q;
      pc_d                  = vector;
      next_pc_d             = vector + 32'd4;
    end

    res.pc_value      = pc_d;
    res.next_pc_value = next_pc_d;
  end

  // Advance architectural state on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= RESET_VECTOR;
      exec_pc_q <= RESET_VECTOR;
      next_pc_q <= RESET_VECTOR + 32'd4;
      branch_q  <= 1'b0;
      delay_q   <= 1'b0;
      sr_q      <= SR_RESET;
      cause_q   <= '0;
      epc_q     <= '0;
    end else if (in_acc) begin
      pc_q      <= pc_d;
      exec_pc_q <= exec_pc_d;
      next_pc_q <= next_pc_d;
      branch_q  <= branch_d;
      delay_q   <= delay_d;
      sr_q      <= sr_d;
      cause_q   <= cause_d;
      epc_q     <= epc_d;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.phys_address      = out_q.phys_address;
  assign out_o.read_value        = out_q.read_value;
  assign out_o.fetch_fault       = out_q.fetch_fault;
  assign out_o.access_suppressed = out_q.access_suppressed;
  assign out_o.bad_register      = out_q.bad_register;
  assign out_o.pc_value          = out_q.pc_value;
  assign out_o.next_pc_value     = out_q.next_pc_value;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the pc sequencer and COP0 exception unit core.
// Needs mpc_pkg, the mpc_in_if / mpc_out_if channel interfaces and the core.
// Drives directed and random event words and checks each result word against a predictor.

module tb_top;
  import mpc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned RX_HOLD_CYCLES  = 60;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTED    = 10;
  localparam int unsigned DRAIN_CYCLES    = 4;

  // One event word as seen on the input channel
  typedef struct {
    action_e            act;
    logic [31:0]        target;
    logic signed [31:0] offset;
    logic [4:0]         code;
    logic [4:0]         reg_num;
    logic [31:0]        wval;
    logic [31:0]        daddr;
  } cpu_event_t;

  // Predictor of the pc pipeline and COP0 state plus the queue of results it owes
  class pc_cop0_scoreboard;
    logic [31:0] pc;
    logic [31:0] cur_pc;
    logic [31:0] npc;
    logic        branch_pend;
    logic        delay_slot;
    logic [31:0] sr;
    logic [31:0] cause;
    logic [31:0] epc;
    result_t     owed_results[$];
    int unsigned mismatches;

    function new();
      pc          = RESET_VECTOR;
      cur_pc      = RESET_VECTOR;
      npc         = RESET_VECTOR + 32'd4;
      branch_pend = 1'b0;
      delay_slot  = 1'b0;
      sr          = SR_RESET;
      cause       = '0;
      epc         = '0;
      mismatches  = 0;
    endfunction

    // kseg0 drops bit 31, kseg1 drops bits 31:29, other segments pass through
    function logic [31:0] segment_map(logic [31:0] a);
      case (a[31:29])
        3'd4:    return {1'b0, a[30:0]};
        3'd5:    return {3'b000, a[28:0]};
        default: return a;
      endcase
    endfunction

    // Push the mode stack, record BD, code and EPC, then vector by BEV
    function void take_exception(logic [4:0] code);
      sr[5:0] = {sr[3:0], 2'b00};
      cause[CAUSE_BD_BIT] = delay_slot;
      cause[6:2] = code;
      epc = delay_slot ? cur_pc - 32'd4 : cur_pc;
      pc  = sr[SR_BEV_BIT] ? VECTOR_BOOT : VECTOR_RAM;
      npc = pc + 32'd4;
    endfunction

    function void note_event(cpu_event_t ev);
      result_t r;
      r = '0;
      case (ev.act)
        ACT_FETCH: begin
          if (pc[1:0] != 2'b00) begin
            take_exception(EXC_ADDR_LOAD);
            r.fetch_fault = 1'b1;
          end else begin
            r.phys_address = segment_map(pc);
            cur_pc      = pc;
            pc          = npc;
            npc         = npc + 32'd4;
            delay_slot  = branch_pend;
            branch_pend = 1'b0;
          end
        end
        ACT_JUMP: begin
          branch_pend = 1'b1;
          npc = ev.target;
        end
        ACT_BRANCH: begin
          branch_pend = 1'b1;
          npc = pc + 32'(ev.offset);
        end
        ACT_EXCEPTION: take_exception(ev.code);
        ACT_EXIT_EXC:  sr[5:0] = {2'b00, sr[5:2]};
        ACT_COP0_RD: begin
          case (ev.reg_num)
            REG_SR:    r.read_value = sr;
            REG_CAUSE: r.read_value = cause;
            REG_EPC:   r.read_value = epc;
            default:   r.bad_register = 1'b1;
          endcase
        end
        ACT_COP0_WR: begin
          case (ev.reg_num)
            REG_SR:    sr = ev.wval;
            REG_CAUSE: cause = (cause & ~CAUSE_IP_SW) | (ev.wval & CAUSE_IP_SW);
            REG_BPC, REG_BDA, REG_JUMPDEST, REG_DCIC, REG_BDAM, REG_BPCM: ;
            default:   r.bad_register = 1'b1;
          endcase
        end
        ACT_SOFT_RST: begin
          sr          = (sr | SR_RESET) & ~(SR_KUC | SR_IEC);
          epc         = cur_pc;
          pc          = RESET_VECTOR;
          cur_pc      = RESET_VECTOR;
          npc         = RESET_VECTOR + 32'd4;
          branch_pend = 1'b0;
          delay_slot  = 1'b0;
        end
        ACT_DATA: begin
          if (sr[SR_ISC_BIT]) begin
            r.access_suppressed = 1'b1;
          end else begin
            r.phys_address = segment_map(ev.daddr);
          end
        end
        default: ;
      endcase
      r.pc_value      = pc;
      r.next_pc_value = npc;
      owed_results.push_back(r);
    endfunction

    function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b0;
      if (mismatches < MAX_REPORTED) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
      return 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (owed_results.size() == 0) begin
        if (mismatches < MAX_REPORTED) begin
          $display("%0t: result word with nothing expected: pc %h", $realtime, got.pc_value);
        end
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      bad = field_differs("phys_address", want.phys_address, got.phys_address)
          | field_differs("read_value", want.read_value, got.read_value)
          | field_differs("fetch_fault", 32'(want.fetch_fault), 32'(got.fetch_fault))
          | field_differs("access_suppressed", 32'(want.access_suppressed),
                          32'(got.access_suppressed))
          | field_differs("bad_register", 32'(want.bad_register), 32'(got.bad_register))
          | field_differs("pc_value", want.pc_value, got.pc_value)
          | field_differs("next_pc_value", want.next_pc_value, got.next_pc_value);
      if (bad) mismatches++;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mpc_in_if  in_ch();
  mpc_out_if out_ch();

  mips_pc_and_cop0_exception_unit_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pc_cop0_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold_req  = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned stall_cycles = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check result words first, then note accepted event words
  always @(posedge clk_i) begin : monitor
    result_t    got;
    cpu_event_t ev;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.phys_address      = out_ch.phys_address;
        got.read_value        = out_ch.read_value;
        got.fetch_fault       = out_ch.fetch_fault;
        got.access_suppressed = out_ch.access_suppressed;
        got.bad_register      = out_ch.bad_register;
        got.pc_value          = out_ch.pc_value;
        got.next_pc_value     = out_ch.next_pc_value;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        ev.act     = in_ch.action;
        ev.target  = in_ch.target_address;
        ev.offset  = in_ch.branch_offset;
        ev.code    = in_ch.exc_code;
        ev.reg_num = in_ch.reg_index;
        ev.wval    = in_ch.write_value;
        ev.daddr   = in_ch.data_address;
        sb.note_event(ev);
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one event word and hold it until taken
  task automatic send_event(cpu_event_t ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= ev.act;
    in_ch.target_address <= ev.target;
    in_ch.branch_offset  <= ev.offset;
    in_ch.exc_code       <= ev.code;
    in_ch.reg_index      <= ev.reg_num;
    in_ch.write_value    <= ev.wval;
    in_ch.data_address   <= ev.daddr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result word has come back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Directed word: one value for all 32-bit fields, one index for both 5-bit fields
  function automatic cpu_event_t directed_event(action_e act, logic [31:0] value,
                                                logic [4:0] idx);
    cpu_event_t ev;
    ev.act     = act;
    ev.target  = value;
    ev.offset  = value;
    ev.code    = idx;
    ev.reg_num = idx;
    ev.wval    = value;
    ev.daddr   = value;
    return ev;
  endfunction

  // Random word, weighted toward fetch runs with jumps and branches in between
  function automatic cpu_event_t random_event();
    cpu_event_t  ev;
    int unsigned pick;
    ev.target  = $urandom;
    ev.offset  = $urandom;
    ev.code    = 5'($urandom_range(0, 31));
    ev.reg_num = 5'($urandom_range(0, 31));
    ev.wval    = $urandom;
    ev.daddr   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40)      ev.act = ACT_FETCH;
    else if (pick < 48) ev.act = ACT_JUMP;
    else if (pick < 56) ev.act = ACT_BRANCH;
    else if (pick < 62) ev.act = ACT_EXCEPTION;
    else if (pick < 67) ev.act = ACT_EXIT_EXC;
    else if (pick < 75) ev.act = ACT_COP0_RD;
    else if (pick < 85) ev.act = ACT_COP0_WR;
    else if (pick < 88) ev.act = ACT_SOFT_RST;
    else if (pick < 97) ev.act = ACT_DATA;
    else                ev.act = action_e'(4'($urandom_range(9, 15)));
    // Keep jump targets mostly aligned and inside the mapped segments
    case ($urandom_range(0, 3))
      0: ev.target[31:29] = 3'd4;
      1: ev.target[31:29] = 3'd5;
      default: ;
    endcase
    if ($urandom_range(0, 99) >= 15) ev.target[1:0] = 2'b00;
    // Mostly short word-aligned branch offsets
    if ($urandom_range(0, 3) != 0) begin
      ev.offset = (32'($urandom_range(0, 2047)) - 32'd1024) << 2;
      if ($urandom_range(0, 9) == 0) ev.offset[1:0] = 2'($urandom_range(1, 3));
    end
    // Favor the implemented registers and the silently ignored ones
    case ($urandom_range(0, 4))
      0, 1, 2: ev.reg_num = 5'($urandom_range(12, 14));
      3: begin
        case ($urandom_range(0, 5))
          0: ev.reg_num = REG_BPC;
          1: ev.reg_num = REG_BDA;
          2: ev.reg_num = REG_JUMPDEST;
          3: ev.reg_num = REG_DCIC;
          4: ev.reg_num = REG_BDAM;
          default: ev.reg_num = REG_BPCM;
        endcase
      end
      default: ;
    endcase
    // Leave the cache isolated only part of the time
    if (ev.reg_num == REG_SR && $urandom_range(0, 1) == 1) ev.wval[SR_ISC_BIT] = 1'b0;
    return ev;
  endfunction

  initial begin
    cpu_event_t  ev;
    int unsigned counted;
    int unsigned tx_pct[4];
    int unsigned rx_pct[4];
    tx_pct = '{0, 87, 0, 31};
    rx_pct = '{0, 0, 87, 31};

    // Hold inputs at known values through reset
    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_FETCH;
    in_ch.target_address <= '0;
    in_ch.branch_offset  <= '0;
    in_ch.exc_code       <= '0;
    in_ch.reg_index      <= '0;
    in_ch.write_value    <= '0;
    in_ch.data_address   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, delay slot exception, isolated cache, segments, bad registers
    send_event(directed_event(ACT_FETCH, 32'h0, 5'd0));
    send_event(directed_event(ACT_COP0_RD, 32'h0, REG_SR));
    send_event(directed_event(ACT_COP0_RD, 32'h0, REG_CAUSE));
    send_event(directed_event(ACT_COP0_RD, 32'h0, REG_EPC));
    send_event(directed_event(ACT_COP0_RD, 32'h0, 5'd31));
    send_event(directed_event(ACT_JUMP, 32'h8000_1002, 5'd0));
    send_event(directed_event(ACT_FETCH, 32'h0, 5'd0));
    send_event(directed_event(ACT_EXCEPTION, 32'h0, 5'd31));
    send_event(directed_event(ACT_EXIT_EXC, 32'h0, 5'd0));
    send_event(directed_event(ACT_COP0_WR, 32'hffff_ffff, REG_SR));
    send_event(directed_event(ACT_DATA, 32'ha000_0000, 5'd0));
    send_event(directed_event(ACT_COP0_WR, 32'h0, REG_SR));
    send_event(directed_event(ACT_DATA, 32'h8000_0000, 5'd0));
    send_event(directed_event(ACT_DATA, 32'hffff_ffff, 5'd0));
    send_event(directed_event(ACT_DATA, 32'hbfff_ffff, 5'd0));
    send_event(directed_event(ACT_EXCEPTION, 32'h0, 5'd0));
    send_event(directed_event(ACT_BRANCH, 32'h7fff_ffff, 5'd0));
    send_event(directed_event(ACT_FETCH, 32'h0, 5'd0));
    send_event(directed_event(ACT_FETCH, 32'h0, 5'd0));
    send_event(directed_event(ACT_BRANCH, 32'h8000_0000, 5'd0));
    send_event(directed_event(ACT_COP0_WR, 32'hffff_ffff, REG_CAUSE));
    send_event(directed_event(ACT_COP0_WR, 32'hffff_ffff, REG_EPC));
    send_event(directed_event(ACT_COP0_WR, 32'hffff_ffff, REG_BPC));
    send_event(directed_event(ACT_COP0_WR, 32'h0, 5'd0));
    send_event(directed_event(ACT_SOFT_RST, 32'h0, 5'd0));
    send_event(directed_event(action_e'(4'd15), 32'hffff_ffff, 5'd31));
    wait_results_drained();

    // Random phases with different idle patterns; drain between them
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (p == 0 && counted == 20) rx_hold_req = 1'b1;
        ev = random_event();
        send_event(ev);
        if (ev.act <= ACT_DATA) counted++;
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
